/* rtl/core/chacha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_pkg
// Types, constants and quarter-round helpers shared by the ChaCha20 core.
// ----------------------------------------------------------------------------
package chacha_pkg;

   typedef logic [15:0][31:0] state_type;
   typedef logic [3:0][31:0]  quarter_type;

   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      REG_KEY_01   = 3'd0,
      REG_KEY_23   = 3'd1,
      REG_KEY_45   = 3'd2,
      REG_KEY_67   = 3'd3,
      REG_NONCE_01 = 3'd4,
      REG_NONCE_2  = 3'd5
   } reg_index_type;

   localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

   localparam int unsigned ROT_1 = 16;
   localparam int unsigned ROT_2 = 12;
   localparam int unsigned ROT_3 = 8;
   localparam int unsigned ROT_4 = 7;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // One half of a quarter round: two add/xor/rotate steps.
   function automatic quarter_type half_qr(input quarter_type w, input logic second_half);
      logic [31:0] a, b, c, d;
      quarter_type r;
      a = w[0];
      b = w[1];
      c = w[2];
      d = w[3];
      a = a + b;
      d = d ^ a;
      d = second_half ? rotl(d, ROT_3) : rotl(d, ROT_1);
      c = c + d;
      b = b ^ c;
      b = second_half ? rotl(b, ROT_4) : rotl(b, ROT_2);
      r[0] = a;
      r[1] = b;
      r[2] = c;
      r[3] = d;
      return r;
   endfunction

   // Word indexes of quarter q; diag selects the diagonal pattern.
   function automatic logic [3:0] word_a(input logic [1:0] q);
      return {2'b00, q};
   endfunction

   function automatic logic [3:0] word_b(input logic [1:0] q, input logic diag);
      logic [1:0] col;
      col = q + {1'b0, diag};
      return {2'b01, col};
   endfunction

   function automatic logic [3:0] word_c(input logic [1:0] q, input logic diag);
      logic [1:0] col;
      col = q + {diag, 1'b0};
      return {2'b10, col};
   endfunction

   function automatic logic [3:0] word_d(input logic [1:0] q, input logic diag);
      logic [1:0] col;
      col = q + {diag, diag};
      return {2'b11, col};
   endfunction

endpackage
`default_nettype wire

/* rtl/core/chacha_round_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_round_stage
// One pipeline stage: half of a column or diagonal round on all four
// quarters, with the block counter and valid bit carried alongside.
// ----------------------------------------------------------------------------
module chacha_round_stage #(
   parameter int unsigned PHASE = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     advance,
   input  wire                     in_valid,
   input  wire chacha_pkg::state_type in_state,
   input  wire  [31:0]             in_counter,
   output logic                    out_valid,
   output chacha_pkg::state_type   out_state,
   output logic [31:0]             out_counter
);

   localparam logic SECOND_HALF = (PHASE % 2) == 1;
   localparam logic DIAGONAL    = PHASE >= 2;

   chacha_pkg::state_type state_in;
   logic                  valid_ff;
   chacha_pkg::state_type state_ff;
   logic [31:0]           counter_ff;

   always_comb begin
      chacha_pkg::quarter_type qw;
      chacha_pkg::quarter_type qr;
      state_in = in_state;
      for (int q = 0; q < 4; q++) begin
         qw[0] = in_state[chacha_pkg::word_a(2'(q))];
         qw[1] = in_state[chacha_pkg::word_b(2'(q), DIAGONAL)];
         qw[2] = in_state[chacha_pkg::word_c(2'(q), DIAGONAL)];
         qw[3] = in_state[chacha_pkg::word_d(2'(q), DIAGONAL)];
         qr = chacha_pkg::half_qr(qw, SECOND_HALF);
         state_in[chacha_pkg::word_a(2'(q))]           = qr[0];
         state_in[chacha_pkg::word_b(2'(q), DIAGONAL)] = qr[1];
         state_in[chacha_pkg::word_c(2'(q), DIAGONAL)] = qr[2];
         state_in[chacha_pkg::word_d(2'(q), DIAGONAL)] = qr[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff   <= state_in;
         counter_ff <= in_counter;
      end
   end

   assign out_valid   = valid_ff;
   assign out_state   = state_ff;
   assign out_counter = counter_ff;

endmodule
`default_nettype wire

/* rtl/core/chacha20_block_function.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_block_function
// ChaCha20 block function: fully pipelined rounds, keystream out in pairs.
// ----------------------------------------------------------------------------
// Path: input register, the round stages, then the output word register.
// Each block leaves as 8 two-word results on the result port; the round
// pipeline takes an item every cycle unless the output sequencer stalls it.
// Reset: clears all valid bits, the output sequencer and the key/nonce regs.
// ----------------------------------------------------------------------------
module chacha20_block_function #(
   parameter int unsigned DOUBLE_ROUNDS = 10
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [31:0]                           req_block_counter,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [2:0]                            rsp_pair_index,
   output logic [31:0]                           rsp_word_even,
   output logic [31:0]                           rsp_word_odd,
   output logic                                  rsp_last_of_block,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [chacha_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [chacha_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [chacha_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned NUM_STAGES = 4 * DOUBLE_ROUNDS;

   // ---------------------------------------------------------------- config
   logic [63:0] key01_ff, key23_ff, key45_ff, key67_ff, nonce01_ff;
   logic [31:0] nonce2_ff;
   logic [63:0] key01_in, key23_in, key45_in, key67_in, nonce01_in;
   logic [31:0] nonce2_in;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];

   always_comb begin
      key01_in   = key01_ff;
      key23_in   = key23_ff;
      key45_in   = key45_ff;
      key67_in   = key67_ff;
      nonce01_in = nonce01_ff;
      nonce2_in  = nonce2_ff;
      csr_prdata = '0;
      case (csr_index)
         chacha_pkg::REG_KEY_01:   csr_prdata = key01_ff;
         chacha_pkg::REG_KEY_23:   csr_prdata = key23_ff;
         chacha_pkg::REG_KEY_45:   csr_prdata = key45_ff;
         chacha_pkg::REG_KEY_67:   csr_prdata = key67_ff;
         chacha_pkg::REG_NONCE_01: csr_prdata = nonce01_ff;
         chacha_pkg::REG_NONCE_2:  csr_prdata = {32'd0, nonce2_ff};
         default:                  csr_prdata = '0;
      endcase
      if (csr_write) begin
         case (csr_index)
            chacha_pkg::REG_KEY_01:   key01_in   = csr_pwdata;
            chacha_pkg::REG_KEY_23:   key23_in   = csr_pwdata;
            chacha_pkg::REG_KEY_45:   key45_in   = csr_pwdata;
            chacha_pkg::REG_KEY_67:   key67_in   = csr_pwdata;
            chacha_pkg::REG_NONCE_01: nonce01_in = csr_pwdata;
            chacha_pkg::REG_NONCE_2:  nonce2_in  = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff   <= '0;
         key23_ff   <= '0;
         key45_ff   <= '0;
         key67_ff   <= '0;
         nonce01_ff <= '0;
         nonce2_ff  <= '0;
      end else begin
         key01_ff   <= key01_in;
         key23_ff   <= key23_in;
         key45_ff   <= key45_in;
         key67_ff   <= key67_in;
         nonce01_ff <= nonce01_in;
         nonce2_ff  <= nonce2_in;
      end
   end

   // Initial state; user must change key/nonce only while idle, not enforced.
   function automatic chacha_pkg::state_type build_state(input logic [31:0] ctr,
         input logic [63:0] k01, input logic [63:0] k23, input logic [63:0] k45,
         input logic [63:0] k67, input logic [63:0] n01, input logic [31:0] n2);
      chacha_pkg::state_type s;
      s[0]  = chacha_pkg::SIGMA_0;
      s[1]  = chacha_pkg::SIGMA_1;
      s[2]  = chacha_pkg::SIGMA_2;
      s[3]  = chacha_pkg::SIGMA_3;
      s[4]  = k01[31:0];
      s[5]  = k01[63:32];
      s[6]  = k23[31:0];
      s[7]  = k23[63:32];
      s[8]  = k45[31:0];
      s[9]  = k45[63:32];
      s[10] = k67[31:0];
      s[11] = k67[63:32];
      s[12] = ctr;
      s[13] = n01[31:0];
      s[14] = n01[63:32];
      s[15] = n2;
      return s;
   endfunction

   // -------------------------------------------------------------- pipeline
   logic                  advance;
   logic [NUM_STAGES:0]   stage_valid;
   chacha_pkg::state_type stage_state   [NUM_STAGES+1];
   logic [31:0]           stage_counter [NUM_STAGES+1];
   logic                  in_valid_ff;
   logic [31:0]           in_counter_ff;

   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_counter_ff <= req_block_counter;
      end
   end

   assign stage_valid[0]   = in_valid_ff;
   assign stage_counter[0] = in_counter_ff;
   assign stage_state[0]   = build_state(in_counter_ff, key01_ff, key23_ff, key45_ff,
                                         key67_ff, nonce01_ff, nonce2_ff);

   for (genvar j = 1; j <= NUM_STAGES; j++) begin : g_round
      chacha_round_stage #(
         .PHASE ((j - 1) % 4)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (stage_valid[j-1]),
         .in_state    (stage_state[j-1]),
         .in_counter  (stage_counter[j-1]),
         .out_valid   (stage_valid[j]),
         .out_state   (stage_state[j]),
         .out_counter (stage_counter[j])
      );
   end

   // ------------------------------------------------------- output sequencer
   chacha_pkg::state_type init_state;
   chacha_pkg::state_type final_state;
   chacha_pkg::state_type words_ff, words_in;
   logic [2:0]            pair_ff, pair_in;
   logic                  busy_ff, busy_in;
   logic                  rsp_xfer;
   logic                  last_xfer;
   logic                  load_ok;
   logic                  load;

   assign init_state = build_state(stage_counter[NUM_STAGES], key01_ff, key23_ff,
                                   key45_ff, key67_ff, nonce01_ff, nonce2_ff);

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         final_state[k] = stage_state[NUM_STAGES][k] + init_state[k];
      end
   end

   assign rsp_xfer  = busy_ff && !rsp_stall;
   assign last_xfer = rsp_xfer && (pair_ff == 3'd7);
   assign load_ok   = !busy_ff || last_xfer;
   assign advance   = !stage_valid[NUM_STAGES] || load_ok;
   assign load      = stage_valid[NUM_STAGES] && load_ok;

   always_comb begin
      words_in = words_ff;
      pair_in  = pair_ff;
      busy_in  = busy_ff;
      if (load) begin
         words_in = final_state;
         pair_in  = 3'd0;
         busy_in  = 1'b1;
      end else if (rsp_xfer) begin
         // next pair moves down to words 0 and 1
         words_in = words_ff >> 64;
         pair_in  = pair_ff + 3'd1;
         busy_in  = !last_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         pair_ff <= pair_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign rsp_valid         = busy_ff;
   assign rsp_pair_index    = pair_ff;
   assign rsp_word_even     = words_ff[0];
   assign rsp_word_odd      = words_ff[1];
   assign rsp_last_of_block = (pair_ff == 3'd7);

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the ChaCha20 block function end to end. Each block counter sent in
// is run through a local model of the 20-round permutation with the current
// key and nonce, and the eight keystream pairs that come back are compared
// field by field. Both ports idle and stall at random. Key and nonce change
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned N_DOUBLE       = 10;
   localparam int unsigned PIPE_LATENCY   = 4 * N_DOUBLE + 2;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_PHASES  = 6;
   localparam int unsigned PHASE_BLOCKS   = 76;

   // register slots past the last defined one; writes there must be ignored
   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;

   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_mode_type;

   typedef struct packed {
      logic [2:0]  pair_index;
      logic [31:0] word_even;
      logic [31:0] word_odd;
      logic        last_flag;
   } keystream_pair_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [31:0]                       req_block_counter = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [2:0]                        rsp_pair_index;
   logic [31:0]                       rsp_word_even;
   logic [31:0]                       rsp_word_odd;
   logic                              rsp_last_of_block;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [chacha_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [chacha_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [chacha_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   // local copy of the key and nonce registers
   logic [31:0] key_word [0:7];
   logic [31:0] nonce_word [0:2];

   keystream_pair_type keystream_q [$];

   bit steady_flow = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned blocks_sent = 0;
   int unsigned pairs_checked = 0;
   int unsigned settings_loaded = 0;
   int unsigned idle_cycles = 0;

   chacha20_block_function #(
      .DOUBLE_ROUNDS(N_DOUBLE)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_counter(req_block_counter),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pair_index   (rsp_pair_index),
      .rsp_word_even    (rsp_word_even),
      .rsp_word_odd     (rsp_word_odd),
      .rsp_last_of_block(rsp_last_of_block),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic chacha_pkg::state_type quarter_mix(input chacha_pkg::state_type s,
         input int ia, input int ib, input int ic, input int id);
      logic [31:0] a, b, c, d;
      a = s[ia];
      b = s[ib];
      c = s[ic];
      d = s[id];
      a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
      c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
      a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
      c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
      s[ia] = a;
      s[ib] = b;
      s[ic] = c;
      s[id] = d;
      return s;
   endfunction

   function automatic chacha_pkg::state_type predict_keystream(input logic [31:0] counter);
      chacha_pkg::state_type init, work;
      init[0] = chacha_pkg::SIGMA_0;
      init[1] = chacha_pkg::SIGMA_1;
      init[2] = chacha_pkg::SIGMA_2;
      init[3] = chacha_pkg::SIGMA_3;
      for (int i = 0; i < 8; i++) init[4 + i] = key_word[i];
      init[12] = counter;
      for (int i = 0; i < 3; i++) init[13 + i] = nonce_word[i];
      work = init;
      for (int r = 0; r < N_DOUBLE; r++) begin
         work = quarter_mix(work, 0, 4, 8, 12);
         work = quarter_mix(work, 1, 5, 9, 13);
         work = quarter_mix(work, 2, 6, 10, 14);
         work = quarter_mix(work, 3, 7, 11, 15);
         work = quarter_mix(work, 0, 5, 10, 15);
         work = quarter_mix(work, 1, 6, 11, 12);
         work = quarter_mix(work, 2, 7, 8, 13);
         work = quarter_mix(work, 3, 4, 9, 14);
      end
      for (int k = 0; k < 16; k++) work[k] = work[k] + init[k];
      return work;
   endfunction

   // -------------------------------------------------------------- drivers

   // Called at a rising edge; returns at the edge that completes the transfer.
   task automatic send_block(input logic [31:0] counter);
      int unsigned gap;
      chacha_pkg::state_type stream;
      keystream_pair_type entry;
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_block_counter <= counter;
      do @(negedge clock); while (req_stall !== 1'b0);
      stream = predict_keystream(counter);
      for (int k = 0; k < 8; k++) begin
         entry.pair_index = k[2:0];
         entry.word_even  = stream[2 * k];
         entry.word_odd   = stream[2 * k + 1];
         entry.last_flag  = (k == 7);
         keystream_q.push_back(entry);
      end
      blocks_sent++;
      @(posedge clock);
   endtask

   // Hold off input until every pending pair has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (keystream_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         chacha_pkg::REG_KEY_01: begin
            key_word[0] = value[31:0];
            key_word[1] = value[63:32];
         end
         chacha_pkg::REG_KEY_23: begin
            key_word[2] = value[31:0];
            key_word[3] = value[63:32];
         end
         chacha_pkg::REG_KEY_45: begin
            key_word[4] = value[31:0];
            key_word[5] = value[63:32];
         end
         chacha_pkg::REG_KEY_67: begin
            key_word[6] = value[31:0];
            key_word[7] = value[63:32];
         end
         chacha_pkg::REG_NONCE_01: begin
            nonce_word[0] = value[31:0];
            nonce_word[1] = value[63:32];
         end
         chacha_pkg::REG_NONCE_2: nonce_word[2] = value[31:0];
         default: ;
      endcase
      // leave the bus idle between writes
      @(posedge clock);
   endtask

   task automatic load_setting(input fill_mode_type mode);
      logic [63:0] value;
      for (int i = 0; i < 6; i++) begin
         case (mode)
            FILL_ONES:  value = '1;
            FILL_ZEROS: value = '0;
            default:    value = {$urandom, $urandom};
         endcase
         csr_write(i[2:0], value);
      end
      settings_loaded++;
   endtask

   // -------------------------------------------------------------- checker

   initial begin
      keystream_pair_type exp;
      int unsigned hold;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (rsp_valid !== 1'b1);
         // valid high with stall low here: the transfer lands on the next edge
         if (keystream_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected pair %0d even=%h odd=%h last=%b",
                        rsp_pair_index, rsp_word_even, rsp_word_odd, rsp_last_of_block);
         end else begin
            exp = keystream_q.pop_front();
            pairs_checked++;
            if (rsp_pair_index !== exp.pair_index || rsp_word_even !== exp.word_even ||
                rsp_word_odd !== exp.word_odd || rsp_last_of_block !== exp.last_flag) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: pair exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                           exp.pair_index, exp.word_even, exp.word_odd, exp.last_flag,
                           rsp_pair_index, rsp_word_even, rsp_word_odd,
                           rsp_last_of_block);
            end
         end
         @(posedge clock);
      end
   end

   // cycles with no transfer on either port
   always @(negedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d pairs pending",
                  idle_cycles, keystream_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      send_block(32'h0000_0000);
      send_block(32'h0000_0001);
      send_block(32'hFFFF_FFFF);
      send_block(32'h8000_0000);
   endtask

   task automatic test_all_ones_setting();
      wait_drained();
      load_setting(FILL_ONES);
      send_block(32'h0000_0000);
      send_block(32'hFFFF_FFFF);
      send_block(32'hAAAA_AAAA);
      send_block(32'h5555_5555);
   endtask

   // key 00..1f, nonce 00:00:00:09 00:00:00:4a 00:00:00:00, little-endian words
   task automatic test_known_vector();
      wait_drained();
      csr_write(chacha_pkg::REG_KEY_01, 64'h0706_0504_0302_0100);
      csr_write(chacha_pkg::REG_KEY_23, 64'h0f0e_0d0c_0b0a_0908);
      csr_write(chacha_pkg::REG_KEY_45, 64'h1716_1514_1312_1110);
      csr_write(chacha_pkg::REG_KEY_67, 64'h1f1e_1d1c_1b1a_1918);
      csr_write(chacha_pkg::REG_NONCE_01, 64'h4a00_0000_0900_0000);
      csr_write(chacha_pkg::REG_NONCE_2, 64'h0000_0000_0000_0000);
      settings_loaded++;
      send_block(32'h0000_0001);
      send_block(32'h0000_0000);
   endtask

   // upper half of a 64-bit write to the 32-bit nonce register must be dropped
   task automatic test_nonce2_masking();
      wait_drained();
      csr_write(chacha_pkg::REG_NONCE_2, 64'hFFFF_FFFF_1234_5678);
      send_block(32'h0000_0002);
      send_block(32'hFFFF_FFFE);
   endtask

   task automatic test_spare_registers();
      wait_drained();
      csr_write(REG_SPARE_6, '1);
      csr_write(REG_SPARE_7, {$urandom, $urandom});
      send_block(32'h0000_0003);
      send_block(32'h7FFF_FFFF);
   endtask

   task automatic test_back_to_back();
      steady_flow = 1'b1;
      send_block(32'hFFFF_FFFD);
      send_block(32'hFFFF_FFFE);
      send_block(32'hFFFF_FFFF);
      send_block(32'h0000_0000);
      send_block(32'h0000_0001);
      send_block(32'h0000_0002);
      wait_drained();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_blocks();
      fill_mode_type mode;
      logic [31:0] counter;
      int unsigned pick;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         mode = (p == 2) ? FILL_ONES : (p == 4) ? FILL_ZEROS : FILL_RANDOM;
         load_setting(mode);
         steady_flow = (p == 3);
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
               counter = $urandom_range(0, 15);
            else if (pick < 4)
               counter = 32'hFFFF_FFFF - $urandom_range(0, 15);
            else
               counter = $urandom;
            // now and then let the whole pipeline empty mid-phase
            if ($urandom_range(0, 31) == 0) wait_drained();
            send_block(counter);
         end
         steady_flow = 1'b0;
      end
   endtask

   // ----------------------------------------------------------------- main

   initial begin
      for (int i = 0; i < 8; i++) key_word[i] = '0;
      for (int i = 0; i < 3; i++) nonce_word[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_all_ones_setting();
      test_known_vector();
      test_nonce2_masking();
      test_spare_registers();
      test_back_to_back();
      test_random_blocks();

      wait_drained();
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      $display("summary: %0d blocks, %0d keystream pairs checked, %0d key/nonce settings",
               blocks_sent, pairs_checked, settings_loaded);
      $display("summary: %0d mismatches", mismatch_count);
      if (mismatch_count == 0 && keystream_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
